// ----- src/lcvs_pkg.sv -----
// Package for the label centroid/volume statistics block.
// Holds defaults, function codes, register indexes, field widths and the queued command type; no dependencies.
`default_nettype none
package lcvs_pkg;
    localparam int MAX_LABELS_DEF = 4096;
    localparam int MAX_EXTENT_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 12;

    localparam logic [1:0] FUNC_VOXEL = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [2:0] REG_EXT_Z  = 3'd0;
    localparam logic [2:0] REG_EXT_Y  = 3'd1;
    localparam logic [2:0] REG_EXT_X  = 3'd2;
    localparam logic [2:0] REG_MAXLBL = 3'd3;
    localparam logic [2:0] REG_SIZE_Z = 3'd4;
    localparam logic [2:0] REG_SIZE_Y = 3'd5;
    localparam logic [2:0] REG_SIZE_X = 3'd6;

    localparam int CNT_W = 31;
    localparam int SUM_W = 40;
    localparam int VOL_W = 54;
    localparam int CEN_W = 26;

    // queued command between front and back
    typedef struct packed {
        logic [1:0]  func;
        logic        hit;
        logic [15:0] idx;
        logic [11:0] pz;
        logic [11:0] py;
        logic [11:0] px;
    } cmd_t;
endpackage
`default_nettype wire

// ----- src/label_centroid_volume_stats_top.sv -----
// Top level of the label centroid/volume statistics block.
// Depends on lcvs_pkg, lcvs_front, lcvs_fifo, lcvs_back.
//
// Usage: stream voxel labels in raster order (x fastest) as func 0
// requests; the block counts position from the extent registers. A func 1
// request returns one result with count, volume and centroids; func 2
// clears the store and the position. Func 3 is dropped.
// The front accepts a request per cycle into a 4-entry queue while it is not full.
// The back handles a counted voxel as a RAM read, then a write, and drops a
// skipped voxel in the idle state; a read of an in-range label runs multiplies
// and a bit-serial divider over 56 bits, and a clear writes one RAM entry per
// cycle over the whole store. After reset the back sweeps the store the same way;
// requests queue meanwhile, then stall.
// A stalled receiver holds the result register; the back waits and the
// queue fills, then s_ready drops. Registers may be written when idle.
`default_nettype none
module label_centroid_volume_stats_top import lcvs_pkg::*; #(
    parameter int MAX_LABELS = MAX_LABELS_DEF,
    parameter int MAX_EXTENT = MAX_EXTENT_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_func,
    input  wire logic [15:0]       s_voxel_label,
    input  wire logic [12:0]       s_query_label,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [CNT_W-1:0]       m_voxel_count,
    output logic [VOL_W-1:0]       m_phys_volume,
    output logic [CEN_W-1:0]       m_centroid_z,
    output logic [CEN_W-1:0]       m_centroid_y,
    output logic [CEN_W-1:0]       m_centroid_x
);
    logic [10:0] ext_z_reg, ext_y_reg, ext_x_reg;
    logic [12:0] maxl_reg;
    logic [15:0] sz_reg, sy_reg, sx_reg;

    // hold configuration; write by index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_z_reg <= 11'd1024; ext_y_reg <= 11'd1024; ext_x_reg <= 11'd1024;
            maxl_reg  <= 13'd4096;
            sz_reg <= 16'd4096; sy_reg <= 16'd4096; sx_reg <= 16'd4096;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_EXT_Z:  ext_z_reg <= cfg_data[10:0];
                REG_EXT_Y:  ext_y_reg <= cfg_data[10:0];
                REG_EXT_X:  ext_x_reg <= cfg_data[10:0];
                REG_MAXLBL: maxl_reg  <= cfg_data[12:0];
                REG_SIZE_Z: sz_reg    <= cfg_data;
                REG_SIZE_Y: sy_reg    <= cfg_data;
                REG_SIZE_X: sx_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    logic q_full, q_push, q_empty, q_pop;
    cmd_t q_in, q_out;

    lcvs_front #(.MAX_LABELS(MAX_LABELS), .MAX_EXTENT(MAX_EXTENT)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_voxel_label(s_voxel_label), .s_query_label(s_query_label),
        .ext_z(ext_z_reg), .ext_y(ext_y_reg), .ext_x(ext_x_reg),
        .max_label(maxl_reg), .q_full(q_full), .q_push(q_push), .q_cmd(q_in)
    );

    lcvs_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .din(q_in),
        .full(q_full), .pop(q_pop), .empty(q_empty), .dout(q_out)
    );

    lcvs_back #(.MAX_LABELS(MAX_LABELS), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_empty(q_empty), .q_cmd(q_out), .q_pop(q_pop),
        .size_z(sz_reg), .size_y(sy_reg), .size_x(sx_reg),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_voxel_count(m_voxel_count), .m_phys_volume(m_phys_volume),
        .m_centroid_z(m_centroid_z), .m_centroid_y(m_centroid_y),
        .m_centroid_x(m_centroid_x)
    );
endmodule
`default_nettype wire

// ----- src/lcvs_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`default_nettype none
module lcvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- src/lcvs_front.sv -----
// Front end: accepts requests, tracks raster position, classifies labels.
// Depends on lcvs_pkg.
`default_nettype none
module lcvs_front import lcvs_pkg::*; #(
    parameter int MAX_LABELS = MAX_LABELS_DEF,
    parameter int MAX_EXTENT = MAX_EXTENT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [15:0] s_voxel_label,
    input  wire logic [12:0] s_query_label,
    input  wire logic [10:0] ext_z,
    input  wire logic [10:0] ext_y,
    input  wire logic [10:0] ext_x,
    input  wire logic [12:0] max_label,
    input  wire logic        q_full,
    output logic             q_push,
    output cmd_t             q_cmd
);
    logic [11:0] pz_reg, py_reg, px_reg;
    logic [11:0] pz_next, py_next, px_next;
    logic [12:0] ez, ey, ex;
    logic        acc;
    logic [16:0] lbl;
    logic [16:0] qlbl;

    function automatic logic [12:0] eff(input logic [10:0] e);
        if (e == 11'd0) return 13'd1;
        if (13'(e) > 13'(MAX_EXTENT)) return 13'(MAX_EXTENT);
        return 13'(e);
    endfunction

    assign ez = eff(ext_z);
    assign ey = eff(ext_y);
    assign ex = eff(ext_x);
    assign s_ready = !q_full;
    assign acc = s_valid && s_ready;
    assign lbl = {1'b0, s_voxel_label};
    assign qlbl = 17'(s_query_label);

    always_comb begin
        pz_next = pz_reg;
        py_next = py_reg;
        px_next = px_reg;
        if (acc && s_func == FUNC_CLEAR) begin
            pz_next = '0; py_next = '0; px_next = '0;
        end else if (acc && s_func == FUNC_VOXEL) begin
            if (13'(px_reg) + 13'd1 < ex) begin
                px_next = px_reg + 12'd1;
            end else begin
                px_next = '0;
                if (13'(py_reg) + 13'd1 < ey) begin
                    py_next = py_reg + 12'd1;
                end else begin
                    py_next = '0;
                    if (13'(pz_reg) + 13'd1 < ez) pz_next = pz_reg + 12'd1;
                    else pz_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pz_reg <= '0; py_reg <= '0; px_reg <= '0;
        end else begin
            pz_reg <= pz_next; py_reg <= py_next; px_reg <= px_next;
        end
    end

    always_comb begin
        q_cmd      = '0;
        q_cmd.func = s_func;
        q_cmd.pz   = pz_reg;
        q_cmd.py   = py_reg;
        q_cmd.px   = px_reg;
        case (s_func)
            FUNC_VOXEL: begin
                q_cmd.hit = !s_voxel_label[15] && s_voxel_label != 16'd0 &&
                            lbl <= 17'(max_label) && lbl <= 17'(MAX_LABELS);
                q_cmd.idx = s_voxel_label - 16'd1;
            end
            FUNC_READ: begin
                q_cmd.hit = s_query_label != 13'd0 && qlbl <= 17'(MAX_LABELS);
                q_cmd.idx = 16'(s_query_label) - 16'd1;
            end
            default: begin
                q_cmd.hit = 1'b0;
            end
        endcase
    end
    assign q_push = acc && (s_func == FUNC_VOXEL || s_func == FUNC_READ ||
                            s_func == FUNC_CLEAR);
endmodule
`default_nettype wire

// ----- src/lcvs_fifo.sv -----
// Short command queue between front and back.
// Depends on lcvs_pkg.
`default_nettype none
module lcvs_fifo import lcvs_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t din,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output cmd_t      dout
);
    cmd_t        ent_reg [4];
    logic [1:0]  wp_reg, rp_reg;
    logic [2:0]  cnt_reg;
    logic        do_push, do_pop;

    assign full    = cnt_reg == 3'd4;
    assign empty   = cnt_reg == 3'd0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = ent_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (do_push) ent_reg[wp_reg] <= din;
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (do_push) wp_reg <= wp_reg + 2'd1;
            if (do_pop) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(do_push) - 3'(do_pop);
        end
    end
endmodule
`default_nettype wire

// ----- src/lcvs_back.sv -----
// Back end: statistics store, clear sweep, read-modify-write, read math.
// Depends on lcvs_pkg and lcvs_ram.
`default_nettype none
module lcvs_back import lcvs_pkg::*; #(
    parameter int MAX_LABELS = MAX_LABELS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_empty,
    input  wire cmd_t              q_cmd,
    output logic                   q_pop,
    input  wire logic [15:0]       size_z,
    input  wire logic [15:0]       size_y,
    input  wire logic [15:0]       size_x,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [CNT_W-1:0]       m_voxel_count,
    output logic [VOL_W-1:0]       m_phys_volume,
    output logic [CEN_W-1:0]       m_centroid_z,
    output logic [CEN_W-1:0]       m_centroid_y,
    output logic [CEN_W-1:0]       m_centroid_x
);
    localparam int AW  = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int DW  = CNT_W + 3 * SUM_W;
    localparam int NW  = SUM_W + 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [VOL_W-1:0] VOL_MAX = '1;
    localparam logic [CEN_W-1:0] CEN_MAX = '1;

    localparam logic [3:0] ST_RST   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_VRD   = 4'd2;
    localparam logic [3:0] ST_VWR   = 4'd3;
    localparam logic [3:0] ST_RRD   = 4'd4;
    localparam logic [3:0] ST_RLAT  = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;
    localparam logic [3:0] ST_CLR   = 4'd9;
    localparam logic [3:0] ST_VMUL  = 4'd10;

    logic [3:0]    st_reg;
    cmd_t          c_reg;
    logic [AW-1:0] clr_reg;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;

    lcvs_ram #(.WIDTH(DW), .DEPTH(MAX_LABELS)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [CNT_W-1:0] rc;
    logic [SUM_W-1:0] rz, ry, rx;
    assign {rc, rz, ry, rx} = rdata;

    function automatic logic [SUM_W-1:0] sadd(input logic [SUM_W-1:0] a,
                                               input logic [11:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W + 1)'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    logic [CNT_W-1:0] nc;
    assign nc = (rc == CNT_MAX) ? CNT_MAX : rc + CNT_W'(1);

    // hold the popped command's address so the read data stays valid
    assign raddr = (st_reg == ST_IDLE) ? AW'(q_cmd.idx) : AW'(c_reg.idx);
    assign q_pop = st_reg == ST_IDLE && !q_empty;
    always_comb begin
        we = 1'b0; waddr = AW'(c_reg.idx); wdata = '0;
        if (st_reg == ST_CLR || st_reg == ST_RST) begin
            we = 1'b1; waddr = clr_reg;
        end else if (st_reg == ST_VWR) begin
            we = 1'b1;
            wdata = {nc, sadd(rz, c_reg.pz), sadd(ry, c_reg.py), sadd(rx, c_reg.px)};
        end
    end

    // read math registers
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] sz_reg, sy_reg, sx_reg;
    logic [31:0]      el_reg;       // size_z*size_y
    logic [95:0]      vp_reg;       // count*elv, elv 48 bits
    logic [NW-1:0]    num_reg [3];
    logic [NW-1:0]    rem_reg [3];
    logic [NW-1:0]    quo_reg [3];
    logic [5:0]       bit_reg;
    logic [47:0]      elv_reg;

    function automatic logic [CEN_W-1:0] cen(input logic [NW-1:0] q);
        if (cnt_reg == '0) return '0;
        return (q > NW'(CEN_MAX)) ? CEN_MAX : q[CEN_W-1:0];
    endfunction

    // one restoring-division step per lane per cycle
    logic [NW:0]   trem  [3];
    logic [NW-1:0] nrem  [3];
    logic          qb    [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            trem[i] = {rem_reg[i], num_reg[i][NW-1]};
            qb[i]   = trem[i] >= (NW + 1)'(cnt_reg);
            nrem[i] = qb[i] ? NW'(trem[i] - (NW + 1)'(cnt_reg)) : NW'(trem[i]);
        end
    end

    logic [95:0] vr;
    assign vr = vp_reg + (96'd1 << (2 * FRAC_BITS - 1));

    always_ff @(posedge aclk) begin
        if (st_reg == ST_RLAT) begin
            cnt_reg <= rc; sz_reg <= rz; sy_reg <= ry; sx_reg <= rx;
            el_reg  <= size_z * size_y;
        end
        if (st_reg == ST_MUL) begin
            elv_reg <= 48'(el_reg) * 48'(size_x);
            num_reg[0] <= NW'(sz_reg) * NW'(size_z) + NW'(cnt_reg >> 1);
            num_reg[1] <= NW'(sy_reg) * NW'(size_y) + NW'(cnt_reg >> 1);
            num_reg[2] <= NW'(sx_reg) * NW'(size_x) + NW'(cnt_reg >> 1);
            for (int i = 0; i < 3; i++) rem_reg[i] <= '0;
            bit_reg <= 6'(NW);
        end
        if (st_reg == ST_VMUL) begin
            // count * elv split into two 24-bit halves of elv
            vp_reg <= 96'(cnt_reg) * 96'(elv_reg[23:0]) +
                      ((96'(cnt_reg) * 96'(elv_reg[47:24])) << 24);
        end
        if (st_reg == ST_DIV) begin
            for (int i = 0; i < 3; i++) begin
                rem_reg[i] <= nrem[i];
                num_reg[i] <= num_reg[i] << 1;
                quo_reg[i] <= {quo_reg[i][NW-2:0], qb[i]};
            end
            bit_reg <= bit_reg - 6'd1;
        end
        if (st_reg == ST_OUT && !m_valid) begin
            m_voxel_count <= cnt_reg;
            m_phys_volume <= (vr[95:VOL_W + 2 * FRAC_BITS] != '0) ? VOL_MAX :
                             vr[VOL_W + 2 * FRAC_BITS - 1:2 * FRAC_BITS];
            m_centroid_z <= cen(quo_reg[0]);
            m_centroid_y <= cen(quo_reg[1]);
            m_centroid_x <= cen(quo_reg[2]);
            if (!c_reg.hit) begin
                m_voxel_count <= '0; m_phys_volume <= '0;
                m_centroid_z <= '0; m_centroid_y <= '0; m_centroid_x <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_RST;
            clr_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            case (st_reg)
                ST_RST, ST_CLR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(MAX_LABELS - 1)) begin
                        clr_reg <= '0;
                        st_reg  <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (!q_empty) begin
                        c_reg <= q_cmd;
                        case (q_cmd.func)
                            FUNC_VOXEL: st_reg <= q_cmd.hit ? ST_VRD : ST_IDLE;
                            FUNC_READ:  st_reg <= q_cmd.hit ? ST_RRD : ST_OUT;
                            FUNC_CLEAR: st_reg <= ST_CLR;
                            default:    st_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_VRD:  st_reg <= ST_VWR;
                ST_VWR:  st_reg <= ST_IDLE;
                ST_RRD:  st_reg <= ST_RLAT;
                ST_RLAT: st_reg <= ST_MUL;
                ST_MUL:  st_reg <= ST_VMUL;
                ST_VMUL: st_reg <= ST_DIV;
                ST_DIV:  if (bit_reg == 6'd1) st_reg <= ST_OUT;
                ST_OUT: begin
                    if (!m_valid) begin
                        m_valid <= 1'b1;
                        st_reg  <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- tb/sv/lcvs_stats_checker.sv -----
// Checker for the label centroid/volume statistics block.
// Watches the config port, the request channel and the result channel, keeps its
// own copy of the label store and compares every result; depends on lcvs_pkg.
module lcvs_stats_checker import lcvs_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [15:0]      cfg_data,
    input  wire logic             s_valid,
    input  wire logic             s_ready,
    input  wire logic [1:0]       s_func,
    input  wire logic [15:0]      s_voxel_label,
    input  wire logic [12:0]      s_query_label,
    input  wire logic             m_valid,
    input  wire logic             m_ready,
    input  wire logic [CNT_W-1:0] m_voxel_count,
    input  wire logic [VOL_W-1:0] m_phys_volume,
    input  wire logic [CEN_W-1:0] m_centroid_z,
    input  wire logic [CEN_W-1:0] m_centroid_y,
    input  wire logic [CEN_W-1:0] m_centroid_x,
    output int                    fail_count,
    output int                    reads_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLBL = MAX_LABELS_DEF;
    localparam logic [CNT_W-1:0] CNT_SAT = '1;
    localparam logic [SUM_W-1:0] SUM_SAT = '1;
    localparam logic [VOL_W-1:0] VOL_SAT = '1;
    localparam logic [CEN_W-1:0] CEN_SAT = '1;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic [VOL_W-1:0] volume;
        logic [CEN_W-1:0] cz, cy, cx;
    } label_stats_t;

    logic [CNT_W-1:0] lbl_count [NLBL];
    logic [SUM_W-1:0] lbl_sz [NLBL];
    logic [SUM_W-1:0] lbl_sy [NLBL];
    logic [SUM_W-1:0] lbl_sx [NLBL];
    int unsigned pz, py, px;
    logic [10:0] ext_z, ext_y, ext_x;
    logic [12:0] max_lbl;
    logic [15:0] sz_z, sz_y, sz_x;
    label_stats_t stats_q [$];

    function automatic int unsigned clamp_extent(logic [10:0] e);
        if (e == 0) return 1;
        if (e > MAX_EXTENT_DEF) return MAX_EXTENT_DEF;
        return e;
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, int unsigned b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + b;
        return s[SUM_W] ? SUM_SAT : s[SUM_W-1:0];
    endfunction

    function automatic logic [CEN_W-1:0] centroid(logic [SUM_W-1:0] sum, logic [15:0] sz,
                                                    logic [CNT_W-1:0] c);
        logic [63:0] v;
        if (c == 0) return '0;
        v = (64'(sum) * 64'(sz) + 64'(c) / 2) / 64'(c);
        return (v > 64'(CEN_SAT)) ? CEN_SAT : v[CEN_W-1:0];
    endfunction

    function automatic label_stats_t read_stats(logic [12:0] q);
        label_stats_t r;
        logic [127:0] p;
        int unsigned i;
        r = '{default: '0};
        if (q == 0 || q > NLBL) return r;
        i = q - 1;
        r.count = lbl_count[i];
        // round to nearest, ties up, then drop both size fractions
        p = 128'(lbl_count[i]) * 128'(sz_z) * 128'(sz_y) * 128'(sz_x);
        p = (p + (128'd1 << (2 * FRAC_BITS_DEF - 1))) >> (2 * FRAC_BITS_DEF);
        r.volume = (p > 128'(VOL_SAT)) ? VOL_SAT : p[VOL_W-1:0];
        r.cz = centroid(lbl_sz[i], sz_z, lbl_count[i]);
        r.cy = centroid(lbl_sy[i], sz_y, lbl_count[i]);
        r.cx = centroid(lbl_sx[i], sz_x, lbl_count[i]);
        return r;
    endfunction

    task automatic clear_store();
        for (int i = 0; i < NLBL; i++) begin
            lbl_count[i] = '0;
            lbl_sz[i] = '0;
            lbl_sy[i] = '0;
            lbl_sx[i] = '0;
        end
        pz = 0;
        py = 0;
        px = 0;
    endtask

    task automatic count_voxel(logic [15:0] lbl);
        int unsigned i;
        if (!lbl[15] && lbl != 0 && lbl <= max_lbl && lbl <= NLBL) begin
            i = lbl - 1;
            if (lbl_count[i] != CNT_SAT) lbl_count[i] = lbl_count[i] + 1;
            lbl_sz[i] = sat_sum(lbl_sz[i], pz);
            lbl_sy[i] = sat_sum(lbl_sy[i], py);
            lbl_sx[i] = sat_sum(lbl_sx[i], px);
        end
        // raster advance; a position past a shrunk extent wraps here
        if (px + 1 < clamp_extent(ext_x)) begin
            px++;
        end else begin
            px = 0;
            if (py + 1 < clamp_extent(ext_y)) begin
                py++;
            end else begin
                py = 0;
                if (pz + 1 < clamp_extent(ext_z)) pz++;
                else pz = 0;
            end
        end
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_store();
            ext_z = 11'd1024;
            ext_y = 11'd1024;
            ext_x = 11'd1024;
            max_lbl = 13'd4096;
            sz_z = 16'd4096;
            sz_y = 16'd4096;
            sz_x = 16'd4096;
            stats_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_EXT_Z:  ext_z = cfg_data[10:0];
                    REG_EXT_Y:  ext_y = cfg_data[10:0];
                    REG_EXT_X:  ext_x = cfg_data[10:0];
                    REG_MAXLBL: max_lbl = cfg_data[12:0];
                    REG_SIZE_Z: sz_z = cfg_data;
                    REG_SIZE_Y: sz_y = cfg_data;
                    REG_SIZE_X: sz_x = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (stats_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual count %0d",
                             $time, m_voxel_count);
                    fail_count++;
                end else begin
                    label_stats_t e;
                    e = stats_q.pop_front();
                    check_field("voxel_count", 64'(e.count), 64'(m_voxel_count));
                    check_field("phys_volume", 64'(e.volume), 64'(m_phys_volume));
                    check_field("centroid_z", 64'(e.cz), 64'(m_centroid_z));
                    check_field("centroid_y", 64'(e.cy), 64'(m_centroid_y));
                    check_field("centroid_x", 64'(e.cx), 64'(m_centroid_x));
                end
            end
            if (s_valid && s_ready) begin
                case (s_func)
                    FUNC_VOXEL: count_voxel(s_voxel_label);
                    FUNC_READ:  stats_q.push_back(read_stats(s_query_label));
                    FUNC_CLEAR: clear_store();
                    default: ;
                endcase
            end
        end
        reads_pending <= stats_q.size();
    end

    initial begin
        fail_count = 0;
        reads_pending = 0;
    end
endmodule

// ----- tb/sv/tb_label_centroid_volume_stats_top.sv -----
// Testbench top for the label centroid/volume statistics block.
// Drives requests and config writes; checking lives in lcvs_stats_checker.
// Depends on lcvs_pkg, lcvs_stats_checker and the block under test.
module tb_label_centroid_volume_stats_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lcvs_pkg::*;

    // a clear sweeps the whole store, one entry per cycle
    localparam int SETTLE_CYCLES = MAX_LABELS_DEF + 200;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = REG_EXT_Z;
    logic [15:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_func = FUNC_VOXEL;
    logic [15:0] s_voxel_label = '0;
    logic [12:0] s_query_label = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CNT_W-1:0] m_voxel_count;
    logic [VOL_W-1:0] m_phys_volume;
    logic [CEN_W-1:0] m_centroid_z, m_centroid_y, m_centroid_x;
    int fail_count, reads_pending;

    bit quiet = 1'b0;      // no idling on either side
    bit hold_go = 1'b0;    // ask the receiver for its long hold-off
    bit hold_done = 1'b0;
    logic [12:0] cur_max_label = 13'd4096;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    label_centroid_volume_stats_top u_top (.*);

    lcvs_stats_checker u_checker (.*);

    // Receiver: random stalls, one long hold so the queue fills and s_ready drops.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (hold_go && !hold_done) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until accepted; a random gap may come first.
    task automatic send_req(logic [1:0] f, logic [15:0] vlbl, logic [12:0] qlbl);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_voxel_label <= vlbl;
        s_query_label <= qlbl;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        if (idx == REG_MAXLBL) cur_max_label = val[12:0];
    endtask

    // Drain all reads, then let a trailing clear or voxel finish in the back.
    task automatic settle();
        s_valid <= 1'b0;
        cfg_we <= 1'b0;
        @(posedge aclk);
        wait (reads_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(int ez, int ey, int ex, int ml, int sz, int sy, int sx);
        cfg_write(REG_EXT_Z, 16'(ez));
        cfg_write(REG_EXT_Y, 16'(ey));
        cfg_write(REG_EXT_X, 16'(ex));
        cfg_write(REG_MAXLBL, 16'(ml));
        cfg_write(REG_SIZE_Z, 16'(sz));
        cfg_write(REG_SIZE_Y, 16'(sy));
        cfg_write(REG_SIZE_X, 16'(sx));
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_label();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 16'($urandom_range(1, 12));
        if (r < 88) return 16'($urandom);
        if (r < 92) return 16'd0;
        if (r < 96) return 16'(cur_max_label + $urandom_range(0, 1));
        return 16'd4096;
    endfunction

    function automatic logic [12:0] pick_query();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 13'($urandom_range(1, 12));
        if (r < 92) return 13'($urandom);
        if (r < 96) return 13'd0;
        return 13'd4096;
    endfunction

    task automatic run_random(int n);
        int r;
        // open with a read so a held receiver backs the block up
        send_req(FUNC_READ, 16'($urandom), pick_query());
        for (int i = 1; i < n; i++) begin
            r = $urandom_range(0, 999);
            if (r < 10) send_req(FUNC_CLEAR, 16'($urandom), 13'($urandom));
            else if (r < 15) send_req(FUNC_NONE, 16'($urandom), 13'($urandom));
            else if (r < 120) send_req(FUNC_READ, 16'($urandom), pick_query());
            else send_req(FUNC_VOXEL, pick_label(), 13'($urandom));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: label extremes under reset config, reads, a clear, a read.
        send_req(FUNC_VOXEL, 16'd1, 13'd0);
        send_req(FUNC_VOXEL, 16'd4096, 13'd0);
        send_req(FUNC_VOXEL, 16'd0, 13'd0);
        send_req(FUNC_VOXEL, 16'h8000, 13'd0);
        send_req(FUNC_VOXEL, 16'h7FFF, 13'd0);
        send_req(FUNC_VOXEL, 16'hFFFF, 13'd0);
        send_req(FUNC_VOXEL, 16'd4097, 13'd0);
        send_req(FUNC_VOXEL, 16'd1, 13'd0);
        send_req(FUNC_READ, 16'd0, 13'd1);
        send_req(FUNC_READ, 16'd0, 13'd4096);
        send_req(FUNC_READ, 16'd0, 13'd0);
        send_req(FUNC_READ, 16'd0, 13'd4097);
        send_req(FUNC_READ, 16'd0, 13'h1FFF);
        send_req(FUNC_READ, 16'd0, 13'd77);
        send_req(FUNC_NONE, 16'hFFFF, 13'h1FFF);
        send_req(FUNC_CLEAR, 16'd0, 13'd0);
        send_req(FUNC_READ, 16'd0, 13'd1);
        settle();

        // Phases through the register extremes; zero extent acts as one,
        // oversize extent as the maximum.
        set_config(2, 3, 4, 8, 4096, 4096, 4096);
        run_random(250);
        settle();
        set_config(0, 1, 5, 0, 65535, 65535, 65535);
        run_random(120);
        settle();
        hold_go = 1'b1;
        set_config(2047, 7, 1024, 8191, 65535, 0, 1);
        run_random(250);
        settle();
        set_config(3, 2, 3, 4096, $urandom, $urandom, $urandom);
        run_random(250);
        settle();
        set_config(5, 5, 5, 12, 0, 0, 0);
        run_random(250);
        settle();
        set_config(1024, 1024, 1, 1, 4096, 8192, 2048);
        run_random(80);
        settle();
        quiet = 1'b1;
        set_config($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                   $urandom_range(1, 20), $urandom, $urandom, $urandom);
        run_random(300);

        s_valid <= 1'b0;
        wait (reads_pending == 0);
        repeat (300) @(posedge aclk);
        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    // Generous cap, far beyond the slowest correct run.
    initial begin
        #30ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
